[design/boolean_expression_evaluator_top_defines.svh]
// ----------------------------------------------------------------------------
// boolean expression evaluator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef BOOLEAN_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define BOOLEAN_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BEE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BEE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/bee_pkg.sv]
// ----------------------------------------------------------------------------
// bee_pkg
// types and character codes for the boolean expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package bee_pkg;

	localparam int DEPTH_W = 6;
	localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

	localparam logic [7:0] CH_TRUE = 8'h74;
	localparam logic [7:0] CH_NOT  = 8'h21;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_OR   = 8'h7c;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_OPEN  = 3'd1,
		PH_A     = 3'd2,
		PH_A_NEG = 3'd3,
		PH_OPER  = 3'd4,
		PH_B     = 3'd5,
		PH_B_NEG = 3'd6,
		PH_CLOSE = 3'd7
	} phase_t;

	typedef struct packed {
		logic neg;
		logic op_or;
		logic val;
		logic second;
	} frame_t;

endpackage

`default_nettype wire

[design/boolean_expression_evaluator_top.sv]
// ----------------------------------------------------------------------------
// boolean_expression_evaluator_top
// a character is registered on accept and parsed from the input register;
//   the result of a closing character is then held in the result register
// throughput: one character per cycle, set by the single parse stage; the
//   input stalls only while a finished result waits and the next one is ready
// reset: arst_n clears control state and the parser waits for a start request
// ----------------------------------------------------------------------------
`default_nettype none

module boolean_expression_evaluator_top #(
	parameter int MAX_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [7:0] ch,
	input  wire logic       start_req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output logic            value,
	output logic            overflow
);

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int DW = bee_pkg::DEPTH_W;
	localparam logic [DW-1:0] MAX_D = DW'(MAX_DEPTH);

	logic [7:0] ch_s1;
	logic       start_s1;
	logic       valid_s1;

	bee_pkg::phase_t phase_q;
	logic [DW-1:0]   depth_q;
	logic            neg_q;
	logic            ovf_q;
	logic            wait_q;
	logic            acc_val_q;
	logic            acc_or_q;

	bee_pkg::frame_t stack_q [MAX_DEPTH];

	logic            rsp_valid_q;
	logic            value_q;
	logic            overflow_q;

	bee_pkg::phase_t ph_c;
	logic [DW-1:0]   depth_c;
	logic            neg_c;
	logic            ovf_c;
	logic            acc_val_c;
	logic            acc_or_c;
	logic            active;

	bee_pkg::phase_t phase_n;
	logic [DW-1:0]   depth_n;
	logic            neg_n;
	logic            ovf_n;
	logic            wait_n;
	logic            acc_val_n;
	logic            acc_or_n;
	logic            push;
	logic [AW-1:0]   push_idx;
	bee_pkg::frame_t push_frame;

	logic            emit;
	logic            res_value;
	logic            res_ovf;
	logic            advance;

	// start request discards the partial parse
	assign active    = start_s1 | ~wait_q;
	assign ph_c      = start_s1 ? bee_pkg::PH_START : phase_q;
	assign depth_c   = start_s1 ? '0 : depth_q;
	assign neg_c     = start_s1 ? 1'b0 : neg_q;
	assign ovf_c     = start_s1 ? 1'b0 : ovf_q;
	assign acc_val_c = start_s1 ? 1'b0 : acc_val_q;
	assign acc_or_c  = start_s1 ? 1'b0 : acc_or_q;

	always_comb begin
		logic            is_var;
		logic            enter;
		logic            enter_second;
		logic            enter_neg;
		logic            dl;
		logic            dl_second;
		logic            dl_val;
		logic [DW-1:0]   dec;
		bee_pkg::frame_t pop_frame;

		is_var       = (ch_s1 == bee_pkg::CH_TRUE);
		enter        = 1'b0;
		enter_second = 1'b0;
		enter_neg    = 1'b0;
		dl           = 1'b0;
		dl_second    = 1'b0;
		dl_val       = 1'b0;
		dec          = depth_c - DW'(1);
		pop_frame    = '0;
		push         = 1'b0;
		push_idx     = depth_c[AW-1:0];
		push_frame   = '0;

		phase_n   = phase_q;
		depth_n   = depth_q;
		neg_n     = neg_q;
		ovf_n     = ovf_q;
		wait_n    = wait_q;
		acc_val_n = acc_val_q;
		acc_or_n  = acc_or_q;

		if (active) begin
			phase_n   = ph_c;
			depth_n   = depth_c;
			neg_n     = neg_c;
			ovf_n     = ovf_c;
			wait_n    = 1'b0;
			acc_val_n = acc_val_c;
			acc_or_n  = acc_or_c;

			case (ph_c)
				bee_pkg::PH_START: begin
					if (ch_s1 == bee_pkg::CH_NOT) begin
						neg_n   = 1'b1;
						phase_n = bee_pkg::PH_OPEN;
					end else begin
						phase_n = bee_pkg::PH_A;
					end
				end
				bee_pkg::PH_OPEN: begin
					phase_n = bee_pkg::PH_A;
				end
				bee_pkg::PH_A, bee_pkg::PH_B: begin
					if (ch_s1 == bee_pkg::CH_NOT) begin
						phase_n = (ph_c == bee_pkg::PH_B) ? bee_pkg::PH_B_NEG
							: bee_pkg::PH_A_NEG;
					end else if (ch_s1 == bee_pkg::CH_OPEN) begin
						enter        = 1'b1;
						enter_second = (ph_c == bee_pkg::PH_B);
					end else begin
						dl        = 1'b1;
						dl_second = (ph_c == bee_pkg::PH_B);
						dl_val    = is_var;
					end
				end
				bee_pkg::PH_A_NEG, bee_pkg::PH_B_NEG: begin
					if (ch_s1 == bee_pkg::CH_OPEN) begin
						enter        = 1'b1;
						enter_second = (ph_c == bee_pkg::PH_B_NEG);
						enter_neg    = 1'b1;
					end else begin
						dl        = 1'b1;
						dl_second = (ph_c == bee_pkg::PH_B_NEG);
						dl_val    = ~is_var;
					end
				end
				bee_pkg::PH_OPER: begin
					acc_or_n = (ch_s1 == bee_pkg::CH_OR);
					phase_n  = bee_pkg::PH_B;
				end
				bee_pkg::PH_CLOSE: begin
					if (depth_c == '0) begin
						wait_n  = 1'b1;
						phase_n = bee_pkg::PH_START;
					end else begin
						depth_n = dec;
						if (dec < MAX_D) begin
							pop_frame = stack_q[dec[AW-1:0]];
						end
						acc_val_n = pop_frame.val;
						acc_or_n  = pop_frame.op_or;
						dl        = 1'b1;
						dl_second = pop_frame.second;
						dl_val    = acc_val_c ^ pop_frame.neg;
					end
				end
				default: begin
					phase_n = bee_pkg::PH_START;
				end
			endcase

			if (enter) begin
				push_frame.neg    = enter_neg;
				push_frame.op_or  = acc_or_c;
				push_frame.val    = acc_val_c;
				push_frame.second = enter_second;
				if (depth_c < MAX_D) begin
					push = 1'b1;
				end else begin
					ovf_n = 1'b1;
				end
				if (depth_c != bee_pkg::DEPTH_SAT) begin
					depth_n = depth_c + DW'(1);
				end else begin
					ovf_n = 1'b1;
				end
				acc_val_n = 1'b0;
				acc_or_n  = 1'b0;
				phase_n   = bee_pkg::PH_A;
			end

			if (dl) begin
				if (dl_second) begin
					acc_val_n = acc_or_n ? (acc_val_n | dl_val) : (acc_val_n & dl_val);
					phase_n   = bee_pkg::PH_CLOSE;
				end else begin
					acc_val_n = dl_val;
					phase_n   = bee_pkg::PH_OPER;
				end
			end
		end
	end

	always_comb begin
		emit      = valid_s1 && active && (ph_c == bee_pkg::PH_CLOSE) && (depth_c == '0);
		res_value = acc_val_c ^ neg_c;
		res_ovf   = ovf_c;
	end

	assign advance   = valid_s1 && (!emit || !rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bee_pkg::PH_START;
			depth_q   <= '0;
			neg_q     <= 1'b0;
			ovf_q     <= 1'b0;
			wait_q    <= 1'b1;
			acc_val_q <= 1'b0;
			acc_or_q  <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_n;
			depth_q   <= depth_n;
			neg_q     <= neg_n;
			ovf_q     <= ovf_n;
			wait_q    <= wait_n;
			acc_val_q <= acc_val_n;
			acc_or_q  <= acc_or_n;
		end
	end

	// frame stack
	always_ff @(posedge clk) begin
		if (advance && push) begin
			stack_q[push_idx] <= push_frame;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q    <= res_value;
			overflow_q <= res_ovf;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;
	assign overflow  = overflow_q;

endmodule

`default_nettype wire

[design/bee_checker.sv]
// ----------------------------------------------------------------------------
// bee_checker
// port-level checks for the boolean expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none

`include "boolean_expression_evaluator_top_defines.svh"

module bee_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic start_req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire logic value,
	input wire logic overflow
);

	`BEE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(value) && $stable(overflow), "result changed while stalled")
	`BEE_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without a waiting result")
	`BEE_ASSERT_NOW(a_start_no_rsp, req_valid && !req_stall && start_req, ##2 !$rose(rsp_valid), "result from a start request")

endmodule

bind boolean_expression_evaluator_top bee_checker u_bee_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// boolean expression evaluator testbench
// feeds parenthesised boolean expressions one character per request, with
// noise, cut-off expressions and deep nesting past the frame stack; a
// scoreboard parses the same characters and checks every value and overflow
// ----------------------------------------------------------------------------
module testbench;

	localparam int STACK_DEPTH = 16;
	localparam int ITEM_TARGET = 1700;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] CH_FALSE = 8'h66;
	localparam logic [7:0] CH_AND   = 8'h26;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	class expr_scoreboard #(int DEPTH = 16);
		typedef struct packed {
			logic truth;
			logic ovf;
		} verdict_t;

		verdict_t due[$];
		int errors;
		bee_pkg::phase_t phase;
		logic [bee_pkg::DEPTH_W-1:0] nest;
		bee_pkg::frame_t frames[DEPTH];
		bit neg_all, ovf_seen, awaiting_start, cur_val, cur_or;

		function new();
			foreach (frames[i]) frames[i] = '0;
			errors = 0;
			nest = '0;
			phase = bee_pkg::PH_START;
			neg_all = 0;
			ovf_seen = 0;
			awaiting_start = 1;
			cur_val = 0;
			cur_or = 0;
		endfunction

		function void hand_operand(bit second, bit v);
			if (second) begin
				cur_val = cur_or ? (cur_val | v) : (cur_val & v);
				phase = bee_pkg::PH_CLOSE;
			end else begin
				cur_val = v;
				phase = bee_pkg::PH_OPER;
			end
		endfunction

		function void open_group(bit second, bit neg);
			bee_pkg::frame_t f;
			f = '{neg: neg, op_or: cur_or, val: cur_val, second: second};
			if (nest < DEPTH)
				frames[nest] = f;
			else
				ovf_seen = 1;
			if (nest != bee_pkg::DEPTH_SAT)
				nest++;
			else
				ovf_seen = 1;
			cur_val = 0;
			cur_or = 0;
			phase = bee_pkg::PH_A;
		endfunction

		function void note_request(logic [7:0] c, logic s);
			bit is_true;
			bit v;
			bee_pkg::frame_t f;
			if (s) begin
				nest = '0;
				phase = bee_pkg::PH_START;
				neg_all = 0;
				ovf_seen = 0;
				awaiting_start = 0;
				cur_val = 0;
				cur_or = 0;
			end else if (awaiting_start) begin
				return;
			end
			is_true = (c == bee_pkg::CH_TRUE);
			case (phase)
				bee_pkg::PH_START: begin
					if (c == bee_pkg::CH_NOT) begin
						neg_all = 1;
						phase = bee_pkg::PH_OPEN;
					end else begin
						phase = bee_pkg::PH_A;
					end
				end
				bee_pkg::PH_OPEN: phase = bee_pkg::PH_A;
				bee_pkg::PH_A, bee_pkg::PH_B: begin
					if (c == bee_pkg::CH_NOT)
						phase = (phase == bee_pkg::PH_A) ? bee_pkg::PH_A_NEG
							: bee_pkg::PH_B_NEG;
					else if (c == bee_pkg::CH_OPEN)
						open_group(phase == bee_pkg::PH_B, 0);
					else
						hand_operand(phase == bee_pkg::PH_B, is_true);
				end
				bee_pkg::PH_A_NEG, bee_pkg::PH_B_NEG: begin
					if (c == bee_pkg::CH_OPEN)
						open_group(phase == bee_pkg::PH_B_NEG, 1);
					else
						hand_operand(phase == bee_pkg::PH_B_NEG, !is_true);
				end
				bee_pkg::PH_OPER: begin
					cur_or = (c == bee_pkg::CH_OR);
					phase = bee_pkg::PH_B;
				end
				default: begin
					v = cur_val;
					if (nest == 0) begin
						due.push_back('{truth: v ^ neg_all, ovf: ovf_seen});
						awaiting_start = 1;
						phase = bee_pkg::PH_START;
					end else begin
						nest--;
						f = (nest < DEPTH) ? frames[nest] : bee_pkg::frame_t'('0);
						cur_val = f.val;
						cur_or = f.op_or;
						hand_operand(f.second, v ^ f.neg);
					end
				end
			endcase
		endfunction

		function void check_result(logic truth, logic ovf);
			verdict_t exp_v;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result value=%0b overflow=%0b", truth, ovf);
				return;
			end
			exp_v = due.pop_front();
			if (ovf !== exp_v.ovf || truth !== exp_v.truth) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected value=%0b overflow=%0b, got value=%0b overflow=%0b",
						exp_v.truth, exp_v.ovf, truth, ovf);
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [7:0] ch;
	logic start_req;
	logic rsp_valid;
	logic rsp_stall;
	logic value;
	logic overflow;

	expr_scoreboard #(STACK_DEPTH) sb;
	logic [7:0] expr_q[$];
	int sent;
	int cycles;
	bit burst;
	bit hold_off;

	boolean_expression_evaluator_top #(
		.MAX_DEPTH(STACK_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.ch(ch),
		.start_req(start_req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.value(value),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(ch, start_req);
			if (rsp_valid && !rsp_stall)
				sb.check_result(value, overflow);
		end
	end

	// response side: random stall runs, quiet during bursts, one long hold on request
	initial begin : receiver
		int run_left;
		int r;
		bit run_stall;
		rsp_stall = 1'b0;
		run_left = 0;
		run_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off = 0;
				run_left = 0;
			end else if (burst) begin
				rsp_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 55) begin
						run_stall = 0;
						run_left = $urandom_range(1, 20);
					end else if (r < 90) begin
						run_stall = 1;
						run_left = $urandom_range(1, 3);
					end else begin
						run_stall = 1;
						run_left = $urandom_range(5, 30);
					end
				end
				rsp_stall <= run_stall;
				run_left--;
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic s);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		ch <= c;
		start_req <= s;
		do @(posedge clk); while (req_stall);
		sent++;
	endtask

	task automatic send_expr(input int cut);
		for (int i = 0; i < cut && i < expr_q.size(); i++) begin
			send_char(expr_q[i], i == 0);
		end
	endtask

	task automatic send_text(input string s);
		expr_q.delete();
		for (int i = 0; i < s.len(); i++)
			expr_q.push_back(s[i]);
		send_expr(expr_q.size());
	endtask

	function automatic logic [7:0] any_char();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] var_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = bee_pkg::CH_TRUE;
			4, 5, 6: c = CH_FALSE;
			default: begin
				do c = any_char(); while (c == bee_pkg::CH_NOT || c == bee_pkg::CH_OPEN);
			end
		endcase
		return c;
	endfunction

	function automatic void gen_operand(input int lvl, input bit chain, input bit nest_it);
		if ($urandom_range(0, 3) == 0)
			expr_q.push_back(bee_pkg::CH_NOT);
		if (lvl > 0 && (chain || nest_it)) begin
			expr_q.push_back(bee_pkg::CH_OPEN);
			gen_body(lvl - 1, chain);
		end else begin
			expr_q.push_back(var_char());
		end
	endfunction

	function automatic void gen_body(input int lvl, input bit chain);
		int r;
		gen_operand(lvl, chain, $urandom_range(0, 1) == 0);
		r = $urandom_range(0, 9);
		expr_q.push_back(r < 5 ? bee_pkg::CH_OR : (r < 8 ? CH_AND : any_char()));
		gen_operand(lvl, 0, !chain && $urandom_range(0, 3) == 0);
		expr_q.push_back($urandom_range(0, 9) < 7 ? CH_CLOSE : any_char());
	endfunction

	function automatic void build_expr(input int lvl, input bit chain);
		logic [7:0] c;
		expr_q.delete();
		if ($urandom_range(0, 3) == 0) begin
			expr_q.push_back(bee_pkg::CH_NOT);
			expr_q.push_back(any_char());
		end else begin
			do c = any_char(); while (c == bee_pkg::CH_NOT);
			expr_q.push_back(c);
		end
		gen_body(lvl, chain);
	endfunction

	initial begin
		int r;
		int deep_left;
		arst_n = 1'b0;
		req_valid = 1'b0;
		ch = 8'h00;
		start_req = 1'b0;
		sent = 0;
		burst = 0;
		hold_off = 0;
		deep_left = 3;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: characters ahead of any start are dropped
		send_char(bee_pkg::CH_TRUE, 1'b0);
		send_char(8'hff, 1'b0);
		send_text("(t|f)");
		send_text("!(f|f)");
		send_text("(t*t)");
		send_text("(!t|(f&!(t|f)))");
		send_text("[f|t]");
		send_text("(t|(f");
		send_text("!(t&t)");
		send_char(bee_pkg::CH_TRUE, 1'b0);
		expr_q = '{8'h00, 8'hff, bee_pkg::CH_OR, bee_pkg::CH_TRUE, 8'hff};
		send_expr(5);
		build_expr(STACK_DEPTH + 1, 1);
		send_expr(expr_q.size());

		// receiver holds off while short expressions keep coming
		burst = 1;
		hold_off = 1;
		for (int i = 0; i < 20; i++) begin
			build_expr($urandom_range(0, 1), 0);
			send_expr(expr_q.size());
		end
		burst = 0;

		while (sent < ITEM_TARGET) begin
			burst = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 80) begin
				build_expr($urandom_range(0, 3), 0);
				send_expr(expr_q.size());
			end else if (r < 86) begin
				build_expr($urandom_range(0, 3), 0);
				send_expr($urandom_range(1, expr_q.size() - 1));
			end else if (r < 93) begin
				repeat ($urandom_range(1, 8))
					send_char(any_char(), $urandom_range(0, 3) == 0);
			end else if (r < 99 || deep_left == 0) begin
				build_expr($urandom_range(14, 18), $urandom_range(0, 1));
				send_expr(expr_q.size());
			end else begin
				deep_left--;
				build_expr($urandom_range(62, 68), 1);
				send_expr(expr_q.size());
			end
		end
		burst = 0;

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
